@@ rtl/acbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, register map, S-box table and AES round functions.
// ----------------------------------------------------------------------------
package acbc_pkg;

    localparam int unsigned BLOCK_W   = 128;
    localparam int unsigned RK_DEPTH  = 15;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned PADDR_W   = 6;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;
    localparam logic [2:0] REG_IV_HIGH  = 3'd5;
    localparam logic [2:0] REG_IV_LOW   = 3'd6;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exp_step;
        logic enc_init;
        logic enc_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic exp_done;
        logic enc_last;
        logic out_free;
    } ctrl_status_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_TABLE[(11'd255 - {3'd0, a}) * 11'd8 +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3;
        for (int j = 0; j < 16; j++) begin
            s[j] = sbox(st[127 - 8 * j -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[c * 4 + j] = s[((c + j) % 4) * 4 + j];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            if (last) begin
                r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end else begin
                r[127 - 32 * c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                r[127 - 32 * c - 8 -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                r[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                r[127 - 32 * c - 24 -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/acbc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module acbc_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 15
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/acbc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_ctrl
// Sequencer for key expansion, round iteration and result hand-over.
// ----------------------------------------------------------------------------
module acbc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic                  in_first,
    output logic                       in_ready,
    input  wire acbc_pkg::ctrl_status_t status,
    output acbc_pkg::ctrl_cmd_t        cmd
);

    acbc_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            acbc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = in_first ? acbc_pkg::ST_EXPAND : acbc_pkg::ST_LOAD;
                end
            end
            acbc_pkg::ST_EXPAND: begin
                if (status.exp_done) begin
                    state_next = acbc_pkg::ST_LOAD;
                end
            end
            acbc_pkg::ST_LOAD: state_next = acbc_pkg::ST_ROUND;
            acbc_pkg::ST_ROUND: begin
                if (status.enc_last) begin
                    state_next = acbc_pkg::ST_FINISH;
                end
            end
            acbc_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = acbc_pkg::ST_IDLE;
                end
            end
            default: state_next = acbc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            acbc_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            acbc_pkg::ST_EXPAND: cmd.exp_step = 1'b1;
            acbc_pkg::ST_LOAD:   cmd.enc_init = 1'b1;
            acbc_pkg::ST_ROUND:  cmd.enc_step = 1'b1;
            acbc_pkg::ST_FINISH: cmd.finish   = status.out_free;
            default: begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/acbc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_datapath
// Key schedule, round-key store, AES round unit, chaining value and result
// register.
// ----------------------------------------------------------------------------
module acbc_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire acbc_pkg::ctrl_cmd_t   cmd,
    output acbc_pkg::ctrl_status_t     status,
    input  wire logic [1:0]            key_size,
    input  wire logic [255:0]          key,
    input  wire logic [127:0]          iv,
    input  wire logic                  in_first,
    input  wire logic                  in_last,
    input  wire logic [127:0]          in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [127:0]               out_data,
    output logic                       out_last
);

    localparam int unsigned RK_AW = $clog2(acbc_pkg::RK_DEPTH);

    logic [127:0] text_reg, text_next;
    logic [127:0] cv_reg;
    logic         last_reg;
    logic [3:0]   nr_reg;
    logic [3:0]   rnd_reg;
    logic [5:0]   idx_reg;
    logic [2:0]   kc_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  win_reg [8];
    logic [95:0]  asm_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         out_last_reg;

    logic [3:0]       nr_sel;
    logic [3:0]       nk;
    logic [5:0]       total_m1;
    logic [31:0]      word_new;
    logic [31:0]      temp;
    logic [31:0]      back_word;
    logic             rk_we;
    logic [RK_AW-1:0] rk_raddr;
    logic [127:0]     rk_rdata;

    assign nr_sel   = (key_size == acbc_pkg::KS_128) ? 4'd10 :
                      (key_size == acbc_pkg::KS_192) ? 4'd12 : 4'd14;
    assign nk       = nr_reg - 4'd6;
    assign total_m1 = {nr_reg, 2'b00} + 6'd3;

    always_comb begin
        case (nk)
            4'd4:    back_word = win_reg[3];
            4'd6:    back_word = win_reg[5];
            default: back_word = win_reg[7];
        endcase
        temp = win_reg[0];
        if (kc_reg == 3'd0) begin
            temp = acbc_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                   ^ {rcon_reg, 24'd0};
        end else if (nk == 4'd8 && kc_reg == 3'd4) begin
            temp = acbc_pkg::sub_word(win_reg[0]);
        end
        if ({2'b00, idx_reg} < {4'd0, nk}) begin
            word_new = key[(3'd7 - idx_reg[2:0]) * 8'd32 +: 32];
        end else begin
            word_new = back_word ^ temp;
        end
    end

    assign rk_we    = cmd.exp_step && (idx_reg[1:0] == 2'd3);
    assign rk_raddr = (cmd.enc_step && rnd_reg != nr_reg) ? RK_AW'(rnd_reg + 4'd1) : '0;

    acbc_ram #(
        .WIDTH (acbc_pkg::BLOCK_W),
        .DEPTH (acbc_pkg::RK_DEPTH)
    ) u_rk_ram (
        .aclk  (aclk),
        .we    (rk_we),
        .waddr (RK_AW'(idx_reg[5:2])),
        .wdata ({asm_reg, word_new}),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    always_comb begin
        text_next = text_reg;
        if (cmd.capture) begin
            text_next = in_data ^ (in_first ? iv : cv_reg);
        end else if (cmd.enc_step) begin
            if (rnd_reg == 4'd0) begin
                text_next = text_reg ^ rk_rdata;
            end else begin
                text_next = acbc_pkg::aes_round(text_reg, rnd_reg == nr_reg) ^ rk_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        text_reg <= text_next;
        if (cmd.capture) begin
            last_reg <= in_last;
            if (in_first) begin
                nr_reg   <= nr_sel;
                idx_reg  <= '0;
                kc_reg   <= '0;
                rcon_reg <= 8'h01;
            end
        end
        if (cmd.exp_step) begin
            idx_reg <= idx_reg + 6'd1;
            kc_reg  <= (kc_reg == nk[2:0] - 3'd1 || (nk == 4'd8 && kc_reg == 3'd7))
                       ? 3'd0 : kc_reg + 3'd1;
            if ({2'b00, idx_reg} >= {4'd0, nk} && kc_reg == 3'd0) begin
                rcon_reg <= acbc_pkg::xtime(rcon_reg);
            end
            win_reg[0] <= word_new;
            for (int k = 1; k < 8; k++) begin
                win_reg[k] <= win_reg[k - 1];
            end
            asm_reg <= {asm_reg[63:0], word_new};
        end
        if (cmd.enc_init) begin
            rnd_reg <= '0;
        end else if (cmd.enc_step) begin
            rnd_reg <= rnd_reg + 4'd1;
        end
        if (cmd.finish) begin
            cv_reg       <= text_reg;
            out_data_reg <= text_reg;
            out_last_reg <= last_reg;
        end
        if (!aresetn) begin
            nr_reg <= 4'd10;
            cv_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.exp_done = cmd.exp_step && (idx_reg == total_m1);
    assign status.enc_last = cmd.enc_step && (rnd_reg == nr_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/aes_cbc_encryptor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cbc_encryptor
// AES-128/192/256 encryption in CBC mode with an APB register port.
// ----------------------------------------------------------------------------
// A block passes through the round unit one AES round per cycle; the chaining
// value serialises successive blocks. A first block also runs the key schedule,
// one key word per cycle. A result is registered after the load, round and
// finish states, and after the key schedule for a first block.
// A finished result waits in an output register while the next block is taken.
// Synchronous active-low reset clears control, chaining value, configuration registers and result valid.
module aes_cbc_encryptor (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [acbc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [acbc_pkg::CFG_W-1:0]   pwdata,
    output logic      [acbc_pkg::CFG_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [127:0]                 s_tdata,  // plain_high, plain_low
    input  wire logic                         s_tlast,  // last_block
    input  wire logic                         s_tuser,  // first_block
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [127:0]                 m_tdata,  // cipher_high, cipher_low
    output logic                              m_tlast   // final_out
);

    logic [1:0]  key_size_reg;
    logic [63:0] key_w0_reg, key_w1_reg, key_w2_reg, key_w3_reg;
    logic [63:0] iv_high_reg, iv_low_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    acbc_pkg::ctrl_cmd_t    cmd;
    acbc_pkg::ctrl_status_t status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg <= '0;
            key_w0_reg   <= '0;
            key_w1_reg   <= '0;
            key_w2_reg   <= '0;
            key_w3_reg   <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                acbc_pkg::REG_KEY_SIZE: key_size_reg <= pwdata[1:0];
                acbc_pkg::REG_KEY_W0:   key_w0_reg   <= pwdata;
                acbc_pkg::REG_KEY_W1:   key_w1_reg   <= pwdata;
                acbc_pkg::REG_KEY_W2:   key_w2_reg   <= pwdata;
                acbc_pkg::REG_KEY_W3:   key_w3_reg   <= pwdata;
                acbc_pkg::REG_IV_HIGH:  iv_high_reg  <= pwdata;
                acbc_pkg::REG_IV_LOW:   iv_low_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            acbc_pkg::REG_KEY_SIZE: prdata = {62'd0, key_size_reg};
            acbc_pkg::REG_KEY_W0:   prdata = key_w0_reg;
            acbc_pkg::REG_KEY_W1:   prdata = key_w1_reg;
            acbc_pkg::REG_KEY_W2:   prdata = key_w2_reg;
            acbc_pkg::REG_KEY_W3:   prdata = key_w3_reg;
            acbc_pkg::REG_IV_HIGH:  prdata = iv_high_reg;
            acbc_pkg::REG_IV_LOW:   prdata = iv_low_reg;
            default:                prdata = '0;
        endcase
    end

    acbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_first (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    acbc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .key_size  (key_size_reg),
        .key       ({key_w0_reg, key_w1_reg, key_w2_reg, key_w3_reg}),
        .iv        ({iv_high_reg, iv_low_reg}),
        .in_first  (s_tuser),
        .in_last   (s_tlast),
        .in_data   ({s_tdata[63:0], s_tdata[127:64]}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  ({m_tdata[63:0], m_tdata[127:64]}),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/acbc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbc_checker
// Port-level assertions for the encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module acbc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         pready,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic         m_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while a block is in progress");

    a_no_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared one cycle after acceptance");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port not ready");

endmodule

bind aes_cbc_encryptor acbc_checker u_acbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
